@@ sv/svf_pkg.sv @@
// Shared types and constants of the state variable filter.
package svf_pkg;

   // Default parameter values.
   localparam int SAMPLE_WIDTH_DEF   = 24;
   localparam int COEF_FRAC_BITS_DEF = 24;
   localparam int STATE_WIDTH_DEF    = 32;

   // Register widths, fixed by the register map.
   localparam int MODE_W = 3;
   localparam int A1_W   = 25;
   localparam int A2_W   = 24;
   localparam int A3_W   = 25;
   localparam int K_W    = 28;

   // The shared multiplier takes the widest coefficient.
   localparam int COEF_W = K_W;

   // Configuration port.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = K_W;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FILTER_MODE = 3'd0,
      CSR_COEF_A1     = 3'd1,
      CSR_COEF_A2     = 3'd2,
      CSR_COEF_A3     = 3'd3,
      CSR_DAMPING_K   = 3'd4
   } csr_index_type;

   // Filter mode codes; the codes above notch act as pass-through.
   localparam logic [MODE_W-1:0] MODE_PASS  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_LOW   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_BAND  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_HIGH  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_NOTCH = 3'd4;

   // Register file contents.
   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [A1_W-1:0]   a1;
      logic [A2_W-1:0]   a2;
      logic [A3_W-1:0]   a3;
      logic [K_W-1:0]    k;
   } cfg_type;

   // Operand pairs of the shared multiplier.
   typedef enum logic [2:0] {
      MUL_A1_BAND = 3'd0,
      MUL_A2_V3   = 3'd1,
      MUL_A2_BAND = 3'd2,
      MUL_A3_V3   = 3'd3,
      MUL_K_V1    = 3'd4
   } mul_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        load_x;
      mul_sel_type mul_sel;
      logic        acc1_init;
      logic        acc1_add;
      logic        acc2_init;
      logic        acc2_add;
      logic        v1_load;
      logic        band_upd;
      logic        v2_load;
      logic        low_upd;
      logic        out_load;
      logic        out_bypass;
   } cmd_type;

endpackage

@@ sv/svf_if.sv @@
// Handshake channel interfaces of the state variable filter.
interface svf_req_if #(
   parameter int SAMPLE_WIDTH = svf_pkg::SAMPLE_WIDTH_DEF
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

interface svf_rsp_if #(
   parameter int SAMPLE_WIDTH = svf_pkg::SAMPLE_WIDTH_DEF
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample_out;

   modport source (output valid, output sample_out, input ready);
   modport sink   (input valid, input sample_out, output ready);
endinterface

interface svf_csr_if;
   logic                               valid;
   logic                               ready;
   logic [svf_pkg::CSR_INDEX_W-1:0]    index;
   logic [svf_pkg::CSR_DATA_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/svf_csr.sv @@
// Configuration registers of the state variable filter.
module svf_csr #(
   parameter int COEF_FRAC_BITS = svf_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [svf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [svf_pkg::CSR_DATA_W-1:0]  csr_data,
   output svf_pkg::cfg_type                cfg
);

   // Damping resets to unity gain, masked to the register width.
   localparam logic [svf_pkg::K_W-1:0] K_RESET = svf_pkg::K_W'(1) << COEF_FRAC_BITS;

   svf_pkg::cfg_type cfg_ff;
   svf_pkg::cfg_type cfg_in;

   // Writes are always taken.
   assign csr_ready = 1'b1;

   // Register write decode; unknown indexes are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (svf_pkg::csr_index_type'(csr_index))
            svf_pkg::CSR_FILTER_MODE: cfg_in.mode = csr_data[svf_pkg::MODE_W-1:0];
            svf_pkg::CSR_COEF_A1:     cfg_in.a1   = csr_data[svf_pkg::A1_W-1:0];
            svf_pkg::CSR_COEF_A2:     cfg_in.a2   = csr_data[svf_pkg::A2_W-1:0];
            svf_pkg::CSR_COEF_A3:     cfg_in.a3   = csr_data[svf_pkg::A3_W-1:0];
            svf_pkg::CSR_DAMPING_K:   cfg_in.k    = csr_data[svf_pkg::K_W-1:0];
            default:                  cfg_in      = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode <= svf_pkg::MODE_PASS;
         cfg_ff.a1   <= '0;
         cfg_ff.a2   <= '0;
         cfg_ff.a3   <= '0;
         cfg_ff.k    <= K_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ sv/svf_ctrl.sv @@
// Sequencing controller of the state variable filter.
module svf_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic [svf_pkg::MODE_W-1:0] mode,
   output svf_pkg::cmd_type           cmd
);

   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_P1   = 9'b000000010,
      ST_P2   = 9'b000000100,
      ST_P3   = 9'b000001000,
      ST_P4   = 9'b000010000,
      ST_P5   = 9'b000100000,
      ST_P6   = 9'b001000000,
      ST_P7   = 9'b010000000,
      ST_DONE = 9'b100000000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      bypass;
   logic      req_accept;
   logic      out_free;

   // Modes outside lowpass to notch pass the sample through.
   assign bypass     = !(mode inside {[svf_pkg::MODE_LOW:svf_pkg::MODE_NOTCH]});
   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;

   // Next state and command decode.
   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.mul_sel    = svf_pkg::MUL_K_V1;
      cmd.out_bypass = bypass;
      case (state_ff)
         ST_IDLE: begin
            cmd.load_x = req_accept;
            if (req_accept) begin
               state_in = bypass ? ST_DONE : ST_P1;
            end
         end
         ST_P1: begin
            cmd.mul_sel = svf_pkg::MUL_A1_BAND;
            state_in    = ST_P2;
         end
         ST_P2: begin
            cmd.mul_sel   = svf_pkg::MUL_A2_V3;
            cmd.acc1_init = 1'b1;
            state_in      = ST_P3;
         end
         ST_P3: begin
            cmd.mul_sel  = svf_pkg::MUL_A2_BAND;
            cmd.acc1_add = 1'b1;
            state_in     = ST_P4;
         end
         ST_P4: begin
            cmd.mul_sel   = svf_pkg::MUL_A3_V3;
            cmd.acc2_init = 1'b1;
            cmd.v1_load   = 1'b1;
            state_in      = ST_P5;
         end
         ST_P5: begin
            cmd.mul_sel  = svf_pkg::MUL_K_V1;
            cmd.acc2_add = 1'b1;
            cmd.band_upd = 1'b1;
            state_in     = ST_P6;
         end
         ST_P6: begin
            cmd.v2_load = 1'b1;
            state_in    = ST_P7;
         end
         ST_P7: begin
            cmd.low_upd = 1'b1;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            // Wait here while the previous result is still held.
            cmd.out_load = out_free;
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Result valid flag of the output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // A held result is never overwritten.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten while held");

   // A filtered request reaches the output stage after a fixed schedule.
   a_schedule: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !bypass) |-> ##8 (state_ff == ST_DONE))
      else $error("filter schedule did not reach the output stage");

   // The lowpass state is updated after the bandpass state, with the v2 load between them.
   a_state_order: assert property (@(posedge clock) disable iff (reset)
      cmd.band_upd |-> ##2 cmd.low_upd)
      else $error("integrator updates out of order");

   // A result is withdrawn only after it was taken.
   a_valid_drop: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_valid_ff) |-> $past(rsp_ready))
      else $error("result dropped without handshake");

endmodule

@@ sv/svf_dp.sv @@
// Datapath of the state variable filter with one shared coefficient multiplier.
module svf_dp #(
   parameter int SAMPLE_WIDTH   = svf_pkg::SAMPLE_WIDTH_DEF,
   parameter int COEF_FRAC_BITS = svf_pkg::COEF_FRAC_BITS_DEF,
   parameter int STATE_WIDTH    = svf_pkg::STATE_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  svf_pkg::cmd_type               cmd,
   input  svf_pkg::cfg_type               cfg,
   input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
   output logic signed [SAMPLE_WIDTH-1:0] sample_out
);

   localparam int SMP = SAMPLE_WIDTH;
   localparam int SW  = STATE_WIDTH;
   localparam int CW  = svf_pkg::COEF_W;
   localparam int OW  = SW + 1;
   localparam int PW  = CW + SW;
   localparam int TW  = SW + 2;
   localparam int AW1 = SW + 3;
   localparam int EW  = SW + 4;

   localparam logic [PW:0] RND_HALF = (PW + 1)'(1) << (COEF_FRAC_BITS - 1);
   localparam logic [PW:0] Q_MAX    = (PW + 1)'({(SW + 1){1'b1}});
   localparam logic signed [TW-1:0] T_MAX = {1'b0, {(SW + 1){1'b1}}};
   localparam logic signed [TW-1:0] T_MIN = {1'b1, {(SW + 1){1'b0}}};
   localparam logic signed [EW-1:0] ST_MAX = {{(EW - SW + 1){1'b0}}, {(SW - 1){1'b1}}};
   localparam logic signed [EW-1:0] ST_MIN = {{(EW - SW + 1){1'b1}}, {(SW - 1){1'b0}}};
   localparam logic signed [EW-1:0] SM_MAX = {{(EW - SMP + 1){1'b0}}, {(SMP - 1){1'b1}}};
   localparam logic signed [EW-1:0] SM_MIN = {{(EW - SMP + 1){1'b1}}, {(SMP - 1){1'b0}}};

   function automatic logic signed [SW-1:0] sat_state(input logic signed [EW-1:0] v);
      if (v > ST_MAX) begin
         sat_state = ST_MAX[SW-1:0];
      end else if (v < ST_MIN) begin
         sat_state = ST_MIN[SW-1:0];
      end else begin
         sat_state = v[SW-1:0];
      end
   endfunction

   function automatic logic signed [SMP-1:0] sat_sample(input logic signed [EW-1:0] v);
      if (v > SM_MAX) begin
         sat_sample = SM_MAX[SMP-1:0];
      end else if (v < SM_MIN) begin
         sat_sample = SM_MIN[SMP-1:0];
      end else begin
         sat_sample = v[SMP-1:0];
      end
   endfunction

   logic signed [SMP-1:0] x_ff;
   logic signed [OW-1:0]  v3_ff;
   logic signed [SW-1:0]  band_ff;
   logic signed [SW-1:0]  band_in;
   logic signed [SW-1:0]  low_ff;
   logic signed [SW-1:0]  low_in;
   logic signed [AW1-1:0] acc1_ff;
   logic signed [EW-1:0]  acc2_ff;
   logic signed [SW-1:0]  v1_ff;
   logic signed [SW-1:0]  v2_ff;
   logic signed [TW-1:0]  kv1_ff;
   logic signed [SMP-1:0] sample_out_ff;
   logic [PW-1:0]         prod_ff;
   logic                  prod_neg_ff;

   logic [CW-1:0]         coef_sel;
   logic signed [OW-1:0]  op_sel;
   logic signed [OW-1:0]  op_negated;
   logic                  op_neg;
   logic [SW-1:0]         op_mag;
   logic [PW-1:0]         prod_in;
   logic [PW:0]           rnd_sum;
   logic [PW:0]           rnd_q;
   logic                  rnd_big;
   logic signed [TW-1:0]  term;
   logic signed [EW-1:0]  y_full;

   // Multiplier operand selection.
   always_comb begin
      case (cmd.mul_sel)
         svf_pkg::MUL_A1_BAND: begin
            coef_sel = CW'(cfg.a1);
            op_sel   = OW'(band_ff);
         end
         svf_pkg::MUL_A2_V3: begin
            coef_sel = CW'(cfg.a2);
            op_sel   = v3_ff;
         end
         svf_pkg::MUL_A2_BAND: begin
            coef_sel = CW'(cfg.a2);
            op_sel   = OW'(band_ff);
         end
         svf_pkg::MUL_A3_V3: begin
            coef_sel = CW'(cfg.a3);
            op_sel   = v3_ff;
         end
         default: begin
            coef_sel = CW'(cfg.k);
            op_sel   = OW'(v1_ff);
         end
      endcase
   end

   // Sign and magnitude form, then the unsigned product.
   assign op_neg     = op_sel[OW-1];
   assign op_negated = -op_sel;
   assign op_mag     = op_neg ? op_negated[SW-1:0] : op_sel[SW-1:0];
   assign prod_in    = PW'(coef_sel) * PW'(op_mag);

   always_ff @(posedge clock) begin
      prod_ff     <= prod_in;
      prod_neg_ff <= op_neg;
   end

   // Round the magnitude to nearest, restore the sign and saturate.
   assign rnd_sum = {1'b0, prod_ff} + RND_HALF;
   assign rnd_q   = rnd_sum >> COEF_FRAC_BITS;
   assign rnd_big = rnd_q > Q_MAX;

   always_comb begin
      if (prod_neg_ff) begin
         term = rnd_big ? T_MIN : -$signed(rnd_q[TW-1:0]);
      end else begin
         term = rnd_big ? T_MAX : $signed(rnd_q[TW-1:0]);
      end
   end

   // Integrator updates: twice the solved value minus the old state.
   assign band_in = sat_state((EW'(v1_ff) <<< 1) - EW'(band_ff));
   assign low_in  = sat_state((EW'(v2_ff) <<< 1) - EW'(low_ff));

   // Output selection by mode.
   always_comb begin
      case (cfg.mode)
         svf_pkg::MODE_LOW:  y_full = EW'(v2_ff);
         svf_pkg::MODE_BAND: y_full = EW'(v1_ff);
         svf_pkg::MODE_HIGH: y_full = EW'(x_ff) - EW'(kv1_ff) - EW'(v2_ff);
         default:            y_full = EW'(x_ff) - EW'(kv1_ff);
      endcase
   end

   // Integrator states.
   always_ff @(posedge clock) begin
      if (reset) begin
         band_ff <= '0;
         low_ff  <= '0;
      end else begin
         if (cmd.band_upd) begin
            band_ff <= band_in;
         end
         if (cmd.low_upd) begin
            low_ff <= low_in;
         end
      end
   end

   // Working registers of one sample.
   always_ff @(posedge clock) begin
      if (cmd.load_x) begin
         x_ff  <= sample_in;
         v3_ff <= OW'(sample_in) - OW'(low_ff);
      end
      if (cmd.acc1_init) begin
         acc1_ff <= AW1'(term);
      end else if (cmd.acc1_add) begin
         acc1_ff <= acc1_ff + AW1'(term);
      end
      if (cmd.acc2_init) begin
         acc2_ff <= EW'(low_ff) + EW'(term);
      end else if (cmd.acc2_add) begin
         acc2_ff <= acc2_ff + EW'(term);
      end
      if (cmd.v1_load) begin
         v1_ff <= sat_state(EW'(acc1_ff));
      end
      if (cmd.v2_load) begin
         v2_ff  <= sat_state(acc2_ff);
         kv1_ff <= term;
      end
      if (cmd.out_load) begin
         sample_out_ff <= cmd.out_bypass ? x_ff : sat_sample(y_full);
      end
   end

   assign sample_out = sample_out_ff;

endmodule

@@ sv/tpt_state_variable_filter.sv @@
// Top level of the second-order zero-delay-feedback state variable filter.
//
// Requests on req_port carry one signed audio sample each; every request
// gives exactly one result on rsp_port, in order. Both channels move a
// request when valid and ready are high at a rising clock edge.
// csr_port writes the registers filter_mode, coef_a1, coef_a2, coef_a3 and
// damping_k at indexes 0 to 4; it is always ready, and other indexes are
// ignored. The user must write registers only while no request is in
// flight; the block itself does not enforce it. A filtered request steps
// through the states P1 to P7 before its result is loaded, and the next
// request is taken only after that load; this is set by the single shared
// coefficient multiplier, which forms five products one after another. In
// pass-through modes the accepted sample goes straight to the output stage,
// and the states are kept.
// A finished result waits in the output register; the next request is
// accepted and worked on meanwhile, and only its final step waits for
// that register to be taken.
// Reset clears both integrator states, the result valid flag and the
// registers (damping_k returns to unity).
module tpt_state_variable_filter #(
   parameter int SAMPLE_WIDTH   = svf_pkg::SAMPLE_WIDTH_DEF,
   parameter int COEF_FRAC_BITS = svf_pkg::COEF_FRAC_BITS_DEF,
   parameter int STATE_WIDTH    = svf_pkg::STATE_WIDTH_DEF
) (
   input logic        clock,
   input logic        reset,
   svf_req_if.sink    req_port,
   svf_rsp_if.source  rsp_port,
   svf_csr_if.sink    csr_port
);

   svf_pkg::cfg_type cfg;
   svf_pkg::cmd_type cmd;

   // Register file.
   svf_csr #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_port.valid),
      .csr_ready (csr_port.ready),
      .csr_index (csr_port.index),
      .csr_data  (csr_port.data),
      .cfg       (cfg)
   );

   // Controller.
   svf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .rsp_valid (rsp_port.valid),
      .rsp_ready (rsp_port.ready),
      .mode      (cfg.mode),
      .cmd       (cmd)
   );

   // Datapath.
   svf_dp #(
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS),
      .STATE_WIDTH    (STATE_WIDTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .cfg        (cfg),
      .sample_in  (req_port.sample_in),
      .sample_out (rsp_port.sample_out)
   );

endmodule

@@ sim/tpt_state_variable_filter_tb.sv @@
// Self-checking testbench of the state variable filter: directed table, then random phases.
module tpt_state_variable_filter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SW  = svf_pkg::SAMPLE_WIDTH_DEF;
   localparam int CFB = svf_pkg::COEF_FRAC_BITS_DEF;
   localparam int STW = svf_pkg::STATE_WIDTH_DEF;

   localparam int CLOCK_PERIOD  = 4;
   localparam int MAX_IDLE      = 6;
   localparam int HOLD_CYCLES   = 300;
   localparam int TAIL_CYCLES   = 12;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int RANDOM_PHASES = 15;
   localparam int PHASE_ITEMS   = 50;
   localparam int DIRECTED_ROWS = 24;

   localparam logic signed [SW-1:0] S_MAX = 24'sh7FFFFF;
   localparam logic signed [SW-1:0] S_MIN = 24'sh800000;

   // Register limits and a typical tuning (g = 0.1, Q near 0.707).
   localparam logic [svf_pkg::A1_W-1:0] A1_TOP  = 25'd16777216;
   localparam logic [svf_pkg::A2_W-1:0] A2_TOP  = 24'd8388608;
   localparam logic [svf_pkg::A3_W-1:0] A3_TOP  = 25'd16777216;
   localparam logic [svf_pkg::K_W-1:0]  K_LOW   = 28'd838861;
   localparam logic [svf_pkg::K_W-1:0]  K_TOP   = 28'd167772160;
   localparam logic [svf_pkg::K_W-1:0]  K_UNITY = 28'd16777216;
   localparam logic [svf_pkg::A1_W-1:0] TYP_A1  = 25'd14570886;
   localparam logic [svf_pkg::A2_W-1:0] TYP_A2  = 24'd1457089;
   localparam logic [svf_pkg::A3_W-1:0] TYP_A3  = 25'd145709;
   localparam logic [svf_pkg::K_W-1:0]  TYP_K   = 28'd23726566;
   localparam real COEF_ONE = 16777216.0;
   localparam real PI       = 3.14159265358979;

   // Mode codes beyond notch, and register indexes that map to nothing.
   localparam logic [svf_pkg::MODE_W-1:0] MODE_UNDEF_LO =
      svf_pkg::MODE_W'(svf_pkg::MODE_NOTCH + 1);
   localparam logic [svf_pkg::MODE_W-1:0] MODE_UNDEF_HI = '1;
   localparam logic [svf_pkg::CSR_INDEX_W-1:0] CSR_FIRST_UNUSED =
      svf_pkg::CSR_INDEX_W'(svf_pkg::CSR_DAMPING_K + 1);

   localparam svf_pkg::cfg_type CFG_NONE       = '0;
   localparam svf_pkg::cfg_type CFG_LOW_ZERO   = '{svf_pkg::MODE_LOW, '0, '0, '0, K_UNITY};
   localparam svf_pkg::cfg_type CFG_HIGH_ZERO  = '{svf_pkg::MODE_HIGH, '0, '0, '0, K_UNITY};
   localparam svf_pkg::cfg_type CFG_NOTCH_ZERO = '{svf_pkg::MODE_NOTCH, '0, '0, '0, K_UNITY};
   localparam svf_pkg::cfg_type CFG_UNDEF_LO   = '{MODE_UNDEF_LO, '0, '0, '0, K_UNITY};
   localparam svf_pkg::cfg_type CFG_UNDEF_HI   = '{MODE_UNDEF_HI, '0, '0, '0, K_UNITY};
   localparam svf_pkg::cfg_type CFG_BAND_EXT   =
      '{svf_pkg::MODE_BAND, A1_TOP, A2_TOP, A3_TOP, K_TOP};
   localparam svf_pkg::cfg_type CFG_NOTCH_TYP  =
      '{svf_pkg::MODE_NOTCH, TYP_A1, TYP_A2, TYP_A3, K_LOW};
   localparam svf_pkg::cfg_type CFG_HIGH_TYP   =
      '{svf_pkg::MODE_HIGH, TYP_A1, TYP_A2, TYP_A3, TYP_K};
   localparam svf_pkg::cfg_type CFG_PASS_TYP   =
      '{svf_pkg::MODE_PASS, TYP_A1, TYP_A2, TYP_A3, TYP_K};
   localparam svf_pkg::cfg_type CFG_LOW_TYP    =
      '{svf_pkg::MODE_LOW, TYP_A1, TYP_A2, TYP_A3, TYP_K};

   typedef struct packed {
      logic                 new_cfg;
      svf_pkg::cfg_type     cfg;
      logic signed [SW-1:0] sample_in;
      logic                 known;
      logic signed [SW-1:0] sample_out;
   } stim_row_type;

   // Directed requests; a row with new_cfg set first drains the filter and
   // loads its settings. Rows with known set carry the result to expect.
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      // Reset settings are pass-through.
      '{1'b0, CFG_NONE, S_MAX, 1'b1, S_MAX},
      '{1'b0, CFG_NONE, S_MIN, 1'b1, S_MIN},
      '{1'b0, CFG_NONE, 24'sd0, 1'b1, 24'sd0},
      '{1'b0, CFG_NONE, -24'sd1, 1'b1, -24'sd1},
      // With zero coefficients the integrators stay at zero.
      '{1'b1, CFG_LOW_ZERO, S_MAX, 1'b1, 24'sd0},
      '{1'b1, CFG_HIGH_ZERO, S_MIN, 1'b1, S_MIN},
      '{1'b1, CFG_NOTCH_ZERO, -24'sd1, 1'b1, -24'sd1},
      // Undefined modes pass the sample through.
      '{1'b1, CFG_UNDEF_LO, 24'sd12345, 1'b1, 24'sd12345},
      '{1'b1, CFG_UNDEF_HI, S_MIN, 1'b1, S_MIN},
      // Largest coefficients and damping with full-scale steps drive saturation.
      '{1'b1, CFG_BAND_EXT, S_MAX, 1'b0, 24'sd0},
      '{1'b0, CFG_NONE, S_MAX, 1'b0, 24'sd0},
      '{1'b0, CFG_NONE, S_MIN, 1'b0, 24'sd0},
      '{1'b0, CFG_NONE, S_MIN, 1'b0, 24'sd0},
      '{1'b0, CFG_NONE, S_MAX, 1'b0, 24'sd0},
      // Typical tuning, first in notch mode with the smallest damping, then in highpass mode.
      '{1'b1, CFG_NOTCH_TYP, S_MAX, 1'b0, 24'sd0},
      '{1'b0, CFG_NONE, S_MIN, 1'b0, 24'sd0},
      '{1'b0, CFG_NONE, 24'sd0, 1'b0, 24'sd0},
      '{1'b0, CFG_NONE, 24'sd1000, 1'b0, 24'sd0},
      '{1'b1, CFG_HIGH_TYP, S_MAX, 1'b0, 24'sd0},
      '{1'b0, CFG_NONE, S_MIN, 1'b0, 24'sd0},
      '{1'b0, CFG_NONE, 24'sd4194304, 1'b0, 24'sd0},
      // Pass-through must hold the states, and lowpass resumes from them.
      '{1'b1, CFG_PASS_TYP, 24'sd777, 1'b1, 24'sd777},
      '{1'b1, CFG_LOW_TYP, 24'sd0, 1'b0, 24'sd0},
      '{1'b0, CFG_NONE, 24'sd0, 1'b0, 24'sd0}
   };

   logic clock = 1'b0;
   logic reset;

   svf_req_if req_bus ();
   svf_rsp_if rsp_bus ();
   svf_csr_if csr_bus ();

   tpt_state_variable_filter u_top (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus),
      .csr_port (csr_bus)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Shadow registers and integrator states of the filter.
   svf_pkg::cfg_type live_cfg = '{svf_pkg::MODE_PASS, '0, '0, '0, K_UNITY};
   longint  band_state = 0;
   longint  low_state = 0;

   // Filtered samples still owed by the block, oldest first.
   logic signed [SW-1:0] awaited_samples [$];

   int mismatches = 0;
   int cycle_count = 0;
   bit no_idle = 1'b0;
   bit hold_rsp_request = 1'b0;

   function automatic longint clamp(input longint v, input int bits);
      longint hi;
      longint lo;
      hi = (longint'(1) << (bits - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   // Coefficient product, rounded on magnitude with ties away from zero.
   function automatic longint coef_scale(input longint unsigned c, input longint v);
      longint unsigned mag;
      longint unsigned q;
      mag = (v < 0) ? longint'(-v) : longint'(v);
      q = (c * mag + (64'd1 << (CFB - 1))) >> CFB;
      return clamp((v < 0) ? -longint'(q) : longint'(q), STW + 2);
   endfunction

   // One step of the trapezoidal filter; updates the integrator states.
   function automatic logic signed [SW-1:0] filter_sample(input logic signed [SW-1:0] x);
      longint xs;
      longint v1;
      longint v2;
      longint v3;
      longint kv1;
      longint y;
      xs = x;
      if (live_cfg.mode == svf_pkg::MODE_PASS || live_cfg.mode > svf_pkg::MODE_NOTCH) begin
         return x;
      end
      v3 = xs - low_state;
      v1 = clamp(coef_scale(live_cfg.a1, band_state) + coef_scale(live_cfg.a2, v3), STW);
      v2 = clamp(low_state + coef_scale(live_cfg.a2, band_state)
                 + coef_scale(live_cfg.a3, v3), STW);
      kv1 = coef_scale(live_cfg.k, v1);
      case (live_cfg.mode)
         svf_pkg::MODE_LOW:  y = v2;
         svf_pkg::MODE_BAND: y = v1;
         svf_pkg::MODE_HIGH: y = xs - kv1 - v2;
         default:            y = xs - kv1;
      endcase
      band_state = clamp(2 * v1 - band_state, STW);
      low_state = clamp(2 * v2 - low_state, STW);
      return SW'(clamp(y, SW));
   endfunction

   // Random settings: a real tuning in half the cases, else random in-range, extreme or arbitrary values.
   function automatic svf_pkg::cfg_type random_settings();
      svf_pkg::cfg_type c;
      int               style;
      real              g;
      real              kd;
      real              a1r;
      c.mode = svf_pkg::MODE_W'($urandom_range(0, (1 << svf_pkg::MODE_W) - 1));
      if ($urandom_range(0, 3) != 0) begin
         c.mode = svf_pkg::MODE_W'($urandom_range(svf_pkg::MODE_LOW, svf_pkg::MODE_NOTCH));
      end
      style = $urandom_range(0, 5);
      if (style <= 2) begin
         g = $tan(PI * real'($urandom_range(1, 4500)) / 10000.0);
         kd = 0.05 + real'($urandom_range(0, 9950)) / 1000.0;
         a1r = 1.0 / (1.0 + g * (g + kd));
         c.a1 = svf_pkg::A1_W'(longint'(a1r * COEF_ONE));
         c.a2 = svf_pkg::A2_W'(longint'(g * a1r * COEF_ONE));
         c.a3 = svf_pkg::A3_W'(longint'(g * g * a1r * COEF_ONE));
         c.k = svf_pkg::K_W'(longint'(kd * COEF_ONE));
      end else if (style == 3) begin
         c.a1 = svf_pkg::A1_W'($urandom_range(0, A1_TOP));
         c.a2 = svf_pkg::A2_W'($urandom_range(0, A2_TOP));
         c.a3 = svf_pkg::A3_W'($urandom_range(0, A3_TOP));
         c.k = svf_pkg::K_W'($urandom_range(K_LOW, K_TOP));
      end else if (style == 4) begin
         c.a1 = $urandom_range(0, 1) ? A1_TOP : '0;
         c.a2 = $urandom_range(0, 1) ? A2_TOP : '0;
         c.a3 = $urandom_range(0, 1) ? A3_TOP : '0;
         c.k = $urandom_range(0, 1) ? K_TOP : K_LOW;
      end else begin
         // Any value the register widths allow.
         c.a1 = svf_pkg::A1_W'($urandom);
         c.a2 = svf_pkg::A2_W'($urandom);
         c.a3 = svf_pkg::A3_W'($urandom);
         c.k = svf_pkg::K_W'($urandom);
      end
      return c;
   endfunction

   function automatic logic signed [SW-1:0] random_sample();
      case ($urandom_range(0, 7))
         0:       return S_MAX;
         1:       return S_MIN;
         2:       return SW'(int'($urandom_range(0, 2000)) - 1000);
         default: return SW'($urandom);
      endcase
   endfunction

   // One register write; the shadow copy follows at the handshake.
   task automatic write_reg(input logic [svf_pkg::CSR_INDEX_W-1:0] index,
                            input logic [svf_pkg::CSR_DATA_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      case (index)
         svf_pkg::CSR_FILTER_MODE: live_cfg.mode = data[svf_pkg::MODE_W-1:0];
         svf_pkg::CSR_COEF_A1:     live_cfg.a1 = data[svf_pkg::A1_W-1:0];
         svf_pkg::CSR_COEF_A2:     live_cfg.a2 = data[svf_pkg::A2_W-1:0];
         svf_pkg::CSR_COEF_A3:     live_cfg.a3 = data[svf_pkg::A3_W-1:0];
         svf_pkg::CSR_DAMPING_K:   live_cfg.k = data[svf_pkg::K_W-1:0];
         default: ;
      endcase
   endtask

   // Loads all registers, junk above each narrower width, plus a write to an unused index.
   task automatic configure(input svf_pkg::cfg_type c);
      logic [svf_pkg::CSR_DATA_W-1:0] junk;
      junk = svf_pkg::CSR_DATA_W'($urandom);
      write_reg(svf_pkg::CSR_INDEX_W'($urandom_range(CSR_FIRST_UNUSED,
                                                     (1 << svf_pkg::CSR_INDEX_W) - 1)), junk);
      junk = svf_pkg::CSR_DATA_W'($urandom);
      write_reg(svf_pkg::CSR_FILTER_MODE, {junk[svf_pkg::CSR_DATA_W-1:svf_pkg::MODE_W], c.mode});
      junk = svf_pkg::CSR_DATA_W'($urandom);
      write_reg(svf_pkg::CSR_COEF_A1, {junk[svf_pkg::CSR_DATA_W-1:svf_pkg::A1_W], c.a1});
      junk = svf_pkg::CSR_DATA_W'($urandom);
      write_reg(svf_pkg::CSR_COEF_A2, {junk[svf_pkg::CSR_DATA_W-1:svf_pkg::A2_W], c.a2});
      junk = svf_pkg::CSR_DATA_W'($urandom);
      write_reg(svf_pkg::CSR_COEF_A3, {junk[svf_pkg::CSR_DATA_W-1:svf_pkg::A3_W], c.a3});
      write_reg(svf_pkg::CSR_DAMPING_K, c.k);
      csr_bus.valid <= 1'b0;
   endtask

   // Offers one request after a random gap, none when no_idle is set; valid stays high for a back-to-back follower.
   task automatic send_sample(input logic signed [SW-1:0] x, input bit known,
                              input logic signed [SW-1:0] typed_out);
      int                   gap;
      logic signed [SW-1:0] predicted;
      gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.sample_in <= x;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predicted = filter_sample(x);
      awaited_samples.push_back(known ? typed_out : predicted);
   endtask

   // Stops offering and waits until every result has come back.
   task automatic settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (awaited_samples.size() != 0) @(posedge clock);
   endtask

   // Stimulus: reset, the directed table, then random phases.
   initial begin
      req_bus.valid <= 1'b0;
      req_bus.sample_in <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.index <= '0;
      csr_bus.data <= '0;
      reset <= 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         if (directed_rows[i].new_cfg) begin
            settle();
            configure(directed_rows[i].cfg);
         end
         send_sample(directed_rows[i].sample_in, directed_rows[i].known,
                     directed_rows[i].sample_out);
      end

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         settle();
         configure(random_settings());
         no_idle = (p % 4 == 3);
         // Once, the result side holds off long enough to back up the requests.
         if (p == 2) hold_rsp_request = 1'b1;
         repeat (PHASE_ITEMS) send_sample(random_sample(), 1'b0, '0);
      end

      settle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("tpt_state_variable_filter_tb OK");
      end else begin
         $display("tpt_state_variable_filter_tb NOT OK");
      end
      $finish;
   end

   // Result side: random stalls, and each result is checked against the oldest one owed.
   initial begin
      int                   idle;
      logic signed [SW-1:0] want;
      rsp_bus.ready <= 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         idle = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
         if (hold_rsp_request) begin
            idle += HOLD_CYCLES;
            hold_rsp_request = 1'b0;
         end
         if (idle > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (idle) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
         if (awaited_samples.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual sample_out %0d",
                     $time, rsp_bus.sample_out);
            mismatches++;
         end else begin
            want = awaited_samples.pop_front();
            if (rsp_bus.sample_out !== want) begin
               $display("%0t: sample_out expected %0d, actual %0d",
                        $time, want, rsp_bus.sample_out);
               mismatches++;
            end
         end
      end
   end

   // Watchdog on the total run length.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tpt_state_variable_filter_tb NOT OK");
      $finish;
   end

endmodule

@@ files.f @@
sv/svf_pkg.sv
sv/svf_if.sv
sv/svf_csr.sv
sv/svf_ctrl.sv
sv/svf_dp.sv
sv/tpt_state_variable_filter.sv
sim/tpt_state_variable_filter_tb.sv
